/* rtl/bgp_pkg.sv */
// ----------------------------------------------------------------------------
// Bilinear grid prolongation package
// Shared types, codes and default sizes for the prolongation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bgp_pkg;

  localparam int COARSE_SIDE_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int COORD_W    = 7;
  localparam int FIELD_W    = 32;
  localparam int HALF_W     = COORD_W - 1;

  localparam logic [COORD_W-1:0] FINE_SIDE_RST = 7'd127;
  localparam logic [COORD_W-1:0] FINE_SIDE_MIN = 7'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [FIELD_W-1:0] coarse_value;
  } in_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] fine_value;
    logic                      status;
  } out_res_t;

  // Controls from the sequencer to the accumulator.
  typedef struct packed {
    logic       clear;
    logic       add;
    logic       fin;
    logic       err;
    logic [1:0] shift;
  } acc_ctl_t;

endpackage

/* rtl/bilinear_grid_prolongation_core.sv */
// ----------------------------------------------------------------------------
// Bilinear grid prolongation core
// Write requests give no result; busy stays low.
// Read requests outside the interior give a status result in the cycle right
// after acceptance; busy stays low. Interior reads issue 1, 2 or 4 coarse
// store reads, one per cycle on the single read port; busy holds through
// the reads and the done state, and the result strobe comes in the cycle
// after the done state. The receiver cannot stall.
// Reset clears control state and sets fine_side to 127; the coarse store
// is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_grid_prolongation_core
  import bgp_pkg::*;
#(
  parameter int COARSE_SIDE = COARSE_SIDE_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_req_t            in_req,
  output logic               out_valid,
  output out_res_t           out_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COORD_W-1:0] cfg_data
);

  localparam int DEPTH = COARSE_SIDE * COARSE_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = (VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W;

  logic [COORD_W-1:0]     fine_side_r;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_addr;
  logic signed [XW-1:0]   wr_ext;
  logic [VALUE_WIDTH-1:0] rd_data;
  acc_ctl_t               ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_side_r <= FINE_SIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      fine_side_r <= cfg_data;
    end
  end

  assign wr_ext = XW'(in_req.coarse_value);

  bgp_seq #(
    .COARSE_SIDE(COARSE_SIDE)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .fine_side(fine_side_r),
    .busy     (busy),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .ctl      (ctl)
  );

  bgp_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_addr),
    .wr_data(wr_ext[VALUE_WIDTH-1:0]),
    .rd_en  (mem_re),
    .rd_addr(mem_addr),
    .rd_data(rd_data)
  );

  bgp_acc #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_data  (rd_data),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

endmodule

/* rtl/bgp_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bgp_seq.sv */
// ----------------------------------------------------------------------------
// Prolongation sequencer
// Accepts requests, checks the fine node, and walks the coarse neighbors
// through the store one read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgp_seq
  import bgp_pkg::*;
#(
  parameter int COARSE_SIDE = COARSE_SIDE_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  in_req_t                                    in_req,
  input  logic [COORD_W-1:0]                         fine_side,
  output logic                                       busy,
  output logic                                       mem_we,
  output logic                                       mem_re,
  output logic [$clog2(COARSE_SIDE*COARSE_SIDE)-1:0] mem_addr,
  output acc_ctl_t                                   ctl
);

  localparam int AW = $clog2(COARSE_SIDE*COARSE_SIDE);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [1:0]        last_r, last_nxt;
  logic              ro_r, ro_nxt;
  logic              co_r, co_nxt;
  logic [HALF_W-1:0] r0_r, r0_nxt;
  logic [HALF_W-1:0] c0_r, c0_nxt;
  logic              pend_r, pend_nxt;

  logic               accept;
  logic               in_ro, in_co;
  logic [HALF_W-1:0]  in_r0, in_c0;
  logic [COORD_W-1:0] lim;
  logic               interior, reachable, wr_inside;
  logic               dr, dc;
  logic [COORD_W-1:0] nr, nc;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign in_ro = in_req.row[0];
  assign in_co = in_req.col[0];
  assign in_r0 = in_req.row[COORD_W-1:1];
  assign in_c0 = in_req.col[COORD_W-1:1];

  assign lim      = fine_side - 7'd2;
  assign interior = (fine_side >= FINE_SIDE_MIN) && (in_req.row != '0) &&
                    (in_req.col != '0) && (in_req.row <= lim) && (in_req.col <= lim);
  assign reachable = (32'(in_r0) + 32'(in_ro) < COARSE_SIDE) &&
                     (32'(in_c0) + 32'(in_co) < COARSE_SIDE);
  assign wr_inside = (32'(in_req.row) < COARSE_SIDE) && (32'(in_req.col) < COARSE_SIDE);

  // Neighbor order: (0,0), then along the odd axis, then the far corner.
  always_comb begin
    if (ro_r && co_r) begin
      dr = k_r[1];
      dc = k_r[0];
    end else begin
      dr = ro_r && k_r[0];
      dc = co_r && k_r[0];
    end
  end

  assign nr = {1'b0, r0_r} + COORD_W'(dr);
  assign nc = {1'b0, c0_r} + COORD_W'(dc);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    ro_nxt    = ro_r;
    co_nxt    = co_r;
    r0_nxt    = r0_r;
    c0_nxt    = c0_r;
    pend_nxt  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = AW'(32'(in_req.row) * COARSE_SIDE + 32'(in_req.col));
    ctl       = '0;
    ctl.shift = 2'(ro_r) + 2'(co_r);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.operation == OP_WRITE) begin
            mem_we = wr_inside;
          end else if (interior && reachable) begin
            ctl.clear = 1'b1;
            ro_nxt    = in_ro;
            co_nxt    = in_co;
            r0_nxt    = in_r0;
            c0_nxt    = in_c0;
            k_nxt     = 2'd0;
            last_nxt  = {in_ro && in_co, in_ro || in_co};
            state_nxt = S_READ;
          end else begin
            ctl.err = 1'b1;
          end
        end
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_addr  = AW'(32'(nr) * COARSE_SIDE + 32'(nc));
        pend_nxt  = 1'b1;
        ctl.add   = pend_r;
        k_nxt     = k_r + 2'd1;
        if (k_r == last_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ctl.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
    k_r    <= k_nxt;
    last_r <= last_nxt;
    ro_r   <= ro_nxt;
    co_r   <= co_nxt;
    r0_r   <= r0_nxt;
    c0_r   <= c0_nxt;
  end

  // The last neighbor's data must be arriving when the sum is finished.
  a_done_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> pend_r)
    else $error("finish without read data");

  // Stores are taken only between reads, so no forwarding is needed.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE) && !pend_r)
    else $error("store write during a read sequence");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> k_r <= last_r)
    else $error("neighbor counter overran");

endmodule

/* rtl/bgp_acc.sv */
// ----------------------------------------------------------------------------
// Prolongation accumulator
// Sums the coarse neighbors in widened form, scales by a shift and
// registers the result, or a zero value with a range status on error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgp_acc
  import bgp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  acc_ctl_t               ctl,
  input  logic [VALUE_WIDTH-1:0] rd_data,
  output logic                   out_valid,
  output out_res_t               out_res
);

  localparam int SW = VALUE_WIDTH + 2;
  localparam int EW = (SW > FIELD_W) ? SW : FIELD_W;

  logic signed [SW-1:0] acc_r, acc_nxt;
  logic signed [SW-1:0] data_ext, sum, scaled;
  logic signed [EW-1:0] res_ext;
  logic                 valid_r;
  out_res_t             res_r, res_nxt;

  assign data_ext = SW'($signed(rd_data));
  assign sum      = acc_r + data_ext;
  // The exact sum, or the floor of its half or quarter.
  assign scaled   = sum >>> ctl.shift;
  assign res_ext  = EW'(scaled);

  always_comb begin
    acc_nxt = acc_r;
    res_nxt = res_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.add) begin
      acc_nxt = sum;
    end
    if (ctl.fin) begin
      res_nxt.fine_value = res_ext[FIELD_W-1:0];
      res_nxt.status     = STATUS_OK;
    end else if (ctl.err) begin
      res_nxt.fine_value = '0;
      res_nxt.status     = STATUS_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.fin || ctl.err;
    end
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.fin && (ctl.err || ctl.clear)))
    else $error("conflicting accumulator controls");

endmodule
